FILE: hdl/hsv_to_rgb_channel_scaled_assert.svh
// Assertion macros for the HSV to RGB converter.
// Both macros take a label, the clock, the active-low reset, a condition and a consequence.
// The checks are compiled out when SYNTH is defined.
`ifndef HSV_TO_RGB_CHANNEL_SCALED_ASSERT_SVH
`define HSV_TO_RGB_CHANNEL_SCALED_ASSERT_SVH
`ifndef SYNTH
// The consequence must hold in the same cycle as the condition.
`define HSV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_channel_scaled: same-cycle check failed");
// The consequence must hold in the cycle after the condition.
`define HSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_channel_scaled: next-cycle check failed");
`else
`define HSV_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HSV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/hsvrgb_pkg.sv
`default_nettype none

package hsvrgb_pkg;

  localparam int HueW   = 9;
  localparam int FracW  = 8;
  localparam int GainW  = 8;
  localparam int FracSqW = 2 * FracW;
  // The weight of a component is 0 to 60, which needs 6 bits.
  localparam int WeightW = 6;
  // Numerators over 65025*60 stay at or below 3901500, which fits in 22 bits.
  localparam int NumW   = 22;
  localparam int ProdW  = NumW + GainW;
  // The denominator has a factor of 4, which is removed by a shift.
  localparam int DropW  = 2;
  localparam int ScW    = ProdW - DropW;
  localparam int DenW   = 20;
  localparam int RecipW = 29;
  localparam int RecipShift = 48;
  localparam int MulW   = ScW + RecipW;
  localparam int SecW   = 3;
  localparam int Lanes  = 3;
  localparam int Stages = 6;
  localparam int CfgIdxW = 2;

  localparam logic [FracW-1:0] FracOne = 8'd255;
  localparam logic [WeightW-1:0] BandWidth = 6'd60;
  localparam logic [DenW-1:0] DenQ = 20'd975375;
  localparam logic [DenW:0] DenTwice = 21'd1950750;
  localparam logic [RecipW-1:0] RecipK =
      RecipW'((64'd1 << RecipShift) / 64'd975375);

  localparam logic [HueW-1:0] Hue60  = 9'd60;
  localparam logic [HueW-1:0] Hue120 = 9'd120;
  localparam logic [HueW-1:0] Hue180 = 9'd180;
  localparam logic [HueW-1:0] Hue240 = 9'd240;
  localparam logic [HueW-1:0] Hue300 = 9'd300;
  localparam logic [HueW-1:0] Hue360 = 9'd360;
  localparam logic [HueW-1:0] Hue480 = 9'd480;

  // Hue bands of 60 degrees each.
  localparam logic [SecW-1:0] SecRedYel  = 3'd0;
  localparam logic [SecW-1:0] SecYelGrn  = 3'd1;
  localparam logic [SecW-1:0] SecGrnCyan = 3'd2;
  localparam logic [SecW-1:0] SecCyanBlu = 3'd3;
  localparam logic [SecW-1:0] SecBluMag  = 3'd4;
  localparam logic [SecW-1:0] SecMagRed  = 3'd5;

  // Channel lanes, which are also the configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegRedGain   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGreenGain = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBlueGain  = 2'd2;

  localparam logic [GainW-1:0] RedGainRst   = 8'd255;
  localparam logic [GainW-1:0] GreenGainRst = 8'd176;
  localparam logic [GainW-1:0] BlueGainRst  = 8'd240;

  typedef logic [NumW-1:0] num_t;
  typedef logic [ScW-1:0] scaled_t;
  typedef logic [GainW-1:0] chan_t;

endpackage

`default_nettype wire

FILE: hdl/hsv_to_rgb_channel_scaled.sv
`default_nettype none
`include "hsv_to_rgb_channel_scaled_assert.svh"

// HSV to RGB converter with a gain for each channel. It takes one request per clock cycle
// while in_stall is low, and it delivers each result while out_stall is low. When out_stall
// is high while a result is waiting, all six stages freeze together, and in_stall follows
// them in the same cycle. The pipeline has six stages. The deepest step is the exact division
// of each scaled channel by 65025*60. It is done as a multiply by a 29-bit reciprocal,
// then a check that adds at most one, and these take two of the six stages.
// Results are exact and truncated toward zero. Each channel lies in 0 to its gain.
// Gains are written on the cfg port, which never stalls. A write to index 3 is ignored.
// Write gains only while no request is in flight.
module hsv_to_rgb_channel_scaled (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [hsvrgb_pkg::HueW-1:0]       in_hue_deg,
  input  wire logic [hsvrgb_pkg::FracW-1:0]      in_saturation,
  input  wire logic [hsvrgb_pkg::FracW-1:0]      in_brightness,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [hsvrgb_pkg::GainW-1:0]           out_red_out,
  output logic [hsvrgb_pkg::GainW-1:0]           out_green_out,
  output logic [hsvrgb_pkg::GainW-1:0]           out_blue_out,
  output logic [3*hsvrgb_pkg::GainW-1:0]         out_packed_grb,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hsvrgb_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [hsvrgb_pkg::GainW-1:0]      cfg_data
);

  // Valid bits travel with the data. Bit 5 is the output register.
  logic [hsvrgb_pkg::Stages-1:0] vld_r;
  logic en;

  hsvrgb_pkg::chan_t gain_r [hsvrgb_pkg::Lanes];

  // Stage 1 holds the fraction products, the weight of X and the hue band.
  logic [hsvrgb_pkg::FracSqW-1:0] sv_r, vns_r;
  logic [hsvrgb_pkg::WeightW-1:0] w_r;
  logic [hsvrgb_pkg::SecW-1:0]    sec1_r;
  // Stage 2 holds the numerators of C, X and M.
  hsvrgb_pkg::num_t cn_r, xn_r, mn_r;
  logic [hsvrgb_pkg::SecW-1:0]    sec2_r;
  // Stage 3 holds the channel numerators. Stage 4 holds them times the gain, divided by 4.
  hsvrgb_pkg::num_t    n3_r [hsvrgb_pkg::Lanes];
  hsvrgb_pkg::scaled_t p4_r [hsvrgb_pkg::Lanes];
  // Stage 5 holds the quotient estimate, which is low by at most one.
  hsvrgb_pkg::scaled_t p5_r [hsvrgb_pkg::Lanes];
  hsvrgb_pkg::chan_t   qe5_r [hsvrgb_pkg::Lanes];
  // Stage 6 is the output register.
  hsvrgb_pkg::chan_t   q6_r [hsvrgb_pkg::Lanes];

  // The whole pipeline advances unless a finished result is being held.
  assign en        = !(vld_r[hsvrgb_pkg::Stages-1] && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r[hsvrgb_pkg::RegRedGain]   <= hsvrgb_pkg::RedGainRst;
      gain_r[hsvrgb_pkg::RegGreenGain] <= hsvrgb_pkg::GreenGainRst;
      gain_r[hsvrgb_pkg::RegBlueGain]  <= hsvrgb_pkg::BlueGainRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        hsvrgb_pkg::RegRedGain:   gain_r[hsvrgb_pkg::RegRedGain]   <= cfg_data;
        hsvrgb_pkg::RegGreenGain: gain_r[hsvrgb_pkg::RegGreenGain] <= cfg_data;
        hsvrgb_pkg::RegBlueGain:  gain_r[hsvrgb_pkg::RegBlueGain]  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[hsvrgb_pkg::Stages-2:0], in_valid};
    end
  end

  // Stage 1: hue modulo 120, the distance from the middle of the band, and the band.
  logic [hsvrgb_pkg::HueW-1:0]    hm, mid_off;
  logic [hsvrgb_pkg::WeightW-1:0] w_nxt;
  logic [hsvrgb_pkg::SecW-1:0]    sec_nxt;

  always_comb begin
    if (in_hue_deg >= hsvrgb_pkg::Hue480) begin
      hm = in_hue_deg - hsvrgb_pkg::Hue480;
    end else if (in_hue_deg >= hsvrgb_pkg::Hue360) begin
      hm = in_hue_deg - hsvrgb_pkg::Hue360;
    end else if (in_hue_deg >= hsvrgb_pkg::Hue240) begin
      hm = in_hue_deg - hsvrgb_pkg::Hue240;
    end else if (in_hue_deg >= hsvrgb_pkg::Hue120) begin
      hm = in_hue_deg - hsvrgb_pkg::Hue120;
    end else begin
      hm = in_hue_deg;
    end
    mid_off = (hm >= hsvrgb_pkg::Hue60) ? (hm - hsvrgb_pkg::Hue60)
                                        : (hsvrgb_pkg::Hue60 - hm);
    w_nxt   = hsvrgb_pkg::BandWidth - mid_off[hsvrgb_pkg::WeightW-1:0];

    // Hues of 360 and above fall into the last band.
    if (in_hue_deg < hsvrgb_pkg::Hue60) begin
      sec_nxt = hsvrgb_pkg::SecRedYel;
    end else if (in_hue_deg < hsvrgb_pkg::Hue120) begin
      sec_nxt = hsvrgb_pkg::SecYelGrn;
    end else if (in_hue_deg < hsvrgb_pkg::Hue180) begin
      sec_nxt = hsvrgb_pkg::SecGrnCyan;
    end else if (in_hue_deg < hsvrgb_pkg::Hue240) begin
      sec_nxt = hsvrgb_pkg::SecCyanBlu;
    end else if (in_hue_deg < hsvrgb_pkg::Hue300) begin
      sec_nxt = hsvrgb_pkg::SecBluMag;
    end else begin
      sec_nxt = hsvrgb_pkg::SecMagRed;
    end
  end

  // Stage 3: place C and X on the channels and add the offset M.
  hsvrgb_pkg::num_t n3_nxt [hsvrgb_pkg::Lanes];

  always_comb begin
    case (sec2_r)
      hsvrgb_pkg::SecRedYel: begin
        n3_nxt[0] = cn_r; n3_nxt[1] = xn_r; n3_nxt[2] = '0;
      end
      hsvrgb_pkg::SecYelGrn: begin
        n3_nxt[0] = xn_r; n3_nxt[1] = cn_r; n3_nxt[2] = '0;
      end
      hsvrgb_pkg::SecGrnCyan: begin
        n3_nxt[0] = '0;   n3_nxt[1] = cn_r; n3_nxt[2] = xn_r;
      end
      hsvrgb_pkg::SecCyanBlu: begin
        n3_nxt[0] = '0;   n3_nxt[1] = xn_r; n3_nxt[2] = cn_r;
      end
      hsvrgb_pkg::SecBluMag: begin
        n3_nxt[0] = xn_r; n3_nxt[1] = '0;   n3_nxt[2] = cn_r;
      end
      default: begin
        n3_nxt[0] = cn_r; n3_nxt[1] = '0;   n3_nxt[2] = xn_r;
      end
    endcase
    for (int i = 0; i < hsvrgb_pkg::Lanes; i++) begin
      n3_nxt[i] = n3_nxt[i] + mn_r;
    end
  end

  // Stages 4 to 6: scale by the gain, divide by 975375 using the reciprocal, then correct.
  logic [hsvrgb_pkg::ProdW-1:0] p4_full [hsvrgb_pkg::Lanes];
  logic [hsvrgb_pkg::MulW-1:0]  recip_prod [hsvrgb_pkg::Lanes];
  hsvrgb_pkg::scaled_t          qd [hsvrgb_pkg::Lanes];
  hsvrgb_pkg::scaled_t          rem [hsvrgb_pkg::Lanes];
  hsvrgb_pkg::chan_t            q6_nxt [hsvrgb_pkg::Lanes];

  always_comb begin
    for (int i = 0; i < hsvrgb_pkg::Lanes; i++) begin
      p4_full[i]    = hsvrgb_pkg::ProdW'(n3_r[i]) * hsvrgb_pkg::ProdW'(gain_r[i]);
      recip_prod[i] = hsvrgb_pkg::MulW'(p4_r[i]) * hsvrgb_pkg::MulW'(hsvrgb_pkg::RecipK);
      qd[i]         = hsvrgb_pkg::ScW'(qe5_r[i]) * hsvrgb_pkg::ScW'(hsvrgb_pkg::DenQ);
      rem[i]        = p5_r[i] - qd[i];
      q6_nxt[i]     = (rem[i] >= hsvrgb_pkg::ScW'(hsvrgb_pkg::DenQ)) ? qe5_r[i] + 8'd1
                                                                     : qe5_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r   <= hsvrgb_pkg::FracSqW'(in_saturation) * hsvrgb_pkg::FracSqW'(in_brightness);
      vns_r  <= hsvrgb_pkg::FracSqW'(hsvrgb_pkg::FracOne - in_saturation) *
                hsvrgb_pkg::FracSqW'(in_brightness);
      w_r    <= w_nxt;
      sec1_r <= sec_nxt;

      cn_r   <= hsvrgb_pkg::NumW'(sv_r) * hsvrgb_pkg::NumW'(hsvrgb_pkg::BandWidth);
      xn_r   <= hsvrgb_pkg::NumW'(sv_r) * hsvrgb_pkg::NumW'(w_r);
      mn_r   <= hsvrgb_pkg::NumW'(vns_r) * hsvrgb_pkg::NumW'(hsvrgb_pkg::BandWidth);
      sec2_r <= sec1_r;

      for (int i = 0; i < hsvrgb_pkg::Lanes; i++) begin
        n3_r[i]  <= n3_nxt[i];
        p4_r[i]  <= p4_full[i][hsvrgb_pkg::ProdW-1:hsvrgb_pkg::DropW];
        p5_r[i]  <= p4_r[i];
        qe5_r[i] <= recip_prod[i][hsvrgb_pkg::RecipShift+hsvrgb_pkg::GainW-1:
                                  hsvrgb_pkg::RecipShift];
        q6_r[i]  <= q6_nxt[i];
      end
    end
  end

  assign out_valid      = vld_r[hsvrgb_pkg::Stages-1];
  assign out_red_out    = q6_r[0];
  assign out_green_out  = q6_r[1];
  assign out_blue_out   = q6_r[2];
  assign out_packed_grb = {q6_r[1], q6_r[0], q6_r[2]};

  // An accepted request always lands in the first stage.
  `HSV_ASSERT_NEXT(a_enter, clk, rst_n, in_valid && !in_stall, vld_r[0])
  // A held result freezes every stage's valid bit.
  `HSV_ASSERT_NEXT(a_freeze, clk, rst_n, !en, vld_r == $past(vld_r))
  // The reciprocal estimate is never low by more than one.
  `HSV_ASSERT_IMPL(a_one_fix, clk, rst_n, vld_r[4], (21'(rem[0]) < hsvrgb_pkg::DenTwice) && (21'(rem[1]) < hsvrgb_pkg::DenTwice) && (21'(rem[2]) < hsvrgb_pkg::DenTwice))

endmodule

`default_nettype wire

FILE: verif/tb_hsv_to_rgb_channel_scaled.sv
`default_nettype none

// Self-checking bench for the gain-scaled HSV to RGB converter.
//
// An initial block runs the test in phases. Each phase after the first writes the three
// channel gains while the block is idle. It then loads the pending request queue
// and waits until every request has been taken and every result has been checked.
// A clocked driver takes requests from that queue and presents them on the input
// channel at the falling clock edge. When a request is accepted at a rising edge,
// its expected color is computed from the gains that the bench holds at that moment.
// A clocked monitor compares every accepted result with the oldest pending prediction.
module tb_hsv_to_rgb_channel_scaled;
  timeunit 1ns;
  timeprecision 1ps;

  // Full denominator of the exact conversion: 65025 * 60.
  localparam int unsigned HsvDen = 32'd3901500;
  // A register index with no register behind it. The block must ignore writes to it.
  localparam logic [hsvrgb_pkg::CfgIdxW-1:0] RegUnused = 2'd3;
  // The block has six stages. The drain wait covers all of them with slack to spare.
  localparam int DrainCycles = 12;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [hsvrgb_pkg::HueW-1:0]  hue;
    logic [hsvrgb_pkg::FracW-1:0] sat;
    logic [hsvrgb_pkg::FracW-1:0] bri;
  } hsv_req_t;

  typedef struct packed {
    hsvrgb_pkg::chan_t               red;
    hsvrgb_pkg::chan_t               green;
    hsvrgb_pkg::chan_t               blue;
    logic [3*hsvrgb_pkg::GainW-1:0]  grb;
  } rgb_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [hsvrgb_pkg::HueW-1:0]      in_hue_deg = '0;
  logic [hsvrgb_pkg::FracW-1:0]     in_saturation = '0;
  logic [hsvrgb_pkg::FracW-1:0]     in_brightness = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [hsvrgb_pkg::GainW-1:0]     out_red_out;
  logic [hsvrgb_pkg::GainW-1:0]     out_green_out;
  logic [hsvrgb_pkg::GainW-1:0]     out_blue_out;
  logic [3*hsvrgb_pkg::GainW-1:0]   out_packed_grb;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [hsvrgb_pkg::CfgIdxW-1:0]   cfg_index = '0;
  logic [hsvrgb_pkg::GainW-1:0]     cfg_data = '0;

  hsv_to_rgb_channel_scaled uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue_deg    (in_hue_deg),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_packed_grb(out_packed_grb),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // The bench keeps its own copy of the gains, indexed like the registers.
  hsvrgb_pkg::chan_t chan_gain [hsvrgb_pkg::Lanes];

  hsv_req_t color_req_q[$];
  rgb_res_t rgb_expected_q[$];

  // Percentage chance that either side starts an idle burst in a given cycle.
  // It is set per phase, and in the final phase calm_mode turns idling off.
  int unsigned idle_pct = 0;
  logic calm_mode = 1'b0;
  int unsigned mismatch_count = 0;

  // The clock has a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The predictor places chroma C, the secondary term X and zero on the channels
  // by 60-degree band. It adds the offset M and scales each sum by its gain. All
  // numerators are over 65025*60, so a single floor division gives the truncated
  // channel. Hues of 360 and above fall into the last band. X still uses the hue
  // mod 120.
  function automatic rgb_res_t hsv_predict(hsv_req_t req);
    int unsigned hue_mod;
    int unsigned mid_off;
    int unsigned chroma_n;
    int unsigned second_n;
    int unsigned offset_n;
    int unsigned lane_n [hsvrgb_pkg::Lanes];
    logic [63:0] prod;
    hsvrgb_pkg::chan_t chan [hsvrgb_pkg::Lanes];
    rgb_res_t res;
    hue_mod  = int'(req.hue) % 120;
    mid_off  = (hue_mod >= 60) ? hue_mod - 60 : 60 - hue_mod;
    chroma_n = int'(req.sat) * int'(req.bri) * 60;
    second_n = int'(req.sat) * int'(req.bri) * (60 - mid_off);
    offset_n = int'(req.bri) * (255 - int'(req.sat)) * 60;
    if (req.hue < hsvrgb_pkg::Hue60) begin
      lane_n = '{chroma_n, second_n, 0};
    end else if (req.hue < hsvrgb_pkg::Hue120) begin
      lane_n = '{second_n, chroma_n, 0};
    end else if (req.hue < hsvrgb_pkg::Hue180) begin
      lane_n = '{0, chroma_n, second_n};
    end else if (req.hue < hsvrgb_pkg::Hue240) begin
      lane_n = '{0, second_n, chroma_n};
    end else if (req.hue < hsvrgb_pkg::Hue300) begin
      lane_n = '{second_n, 0, chroma_n};
    end else begin
      lane_n = '{chroma_n, 0, second_n};
    end
    for (int i = 0; i < hsvrgb_pkg::Lanes; i++) begin
      prod = 64'(lane_n[i] + offset_n) * 64'(chan_gain[i]);
      chan[i] = hsvrgb_pkg::chan_t'(prod / 64'(HsvDen));
    end
    res.red   = chan[hsvrgb_pkg::RegRedGain];
    res.green = chan[hsvrgb_pkg::RegGreenGain];
    res.blue  = chan[hsvrgb_pkg::RegBlueGain];
    res.grb   = {res.green, res.red, res.blue};
    return res;
  endfunction

  // Saturation and brightness hit the ends of their ranges often, because zero
  // and full scale are where the rounding of the channels is most exposed.
  function automatic logic [hsvrgb_pkg::FracW-1:0] rand_frac();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return hsvrgb_pkg::FracOne;
    end
    return hsvrgb_pkg::FracW'($urandom_range(0, 255));
  endfunction

  // Most hues are in the normal 0 to 359 range. The rest use the out-of-range
  // values up to 511, which also toggle the top hue bit.
  function automatic hsv_req_t rand_color();
    hsv_req_t req;
    if ($urandom_range(0, 99) < 85) begin
      req.hue = hsvrgb_pkg::HueW'($urandom_range(0, 359));
    end else begin
      req.hue = hsvrgb_pkg::HueW'($urandom_range(360, 511));
    end
    req.sat = rand_frac();
    req.bri = rand_frac();
    return req;
  endfunction

  // Gain writes happen only while nothing is in flight. A write to the unused
  // index must leave the gain copy unchanged.
  task automatic set_gain(logic [hsvrgb_pkg::CfgIdxW-1:0] idx, hsvrgb_pkg::chan_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    if (idx != RegUnused) begin
      chan_gain[idx] = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_gains(hsvrgb_pkg::chan_t red, hsvrgb_pkg::chan_t green,
                           hsvrgb_pkg::chan_t blue);
    set_gain(hsvrgb_pkg::RegRedGain, red);
    set_gain(hsvrgb_pkg::RegGreenGain, green);
    set_gain(hsvrgb_pkg::RegBlueGain, blue);
  endtask

  // This task waits until the queue is empty, the input valid has dropped and
  // every prediction has been matched. The check runs at the rising edge, where
  // the driver's updates from the falling edge have settled. It then waits out
  // the pipeline latency.
  task automatic wait_idle();
    @(posedge clk);
    while (color_req_q.size() != 0 || in_valid || rgb_expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic run_random(int unsigned count, int unsigned pct);
    idle_pct = pct;
    repeat (count) color_req_q.push_back(rand_color());
    wait_idle();
  endtask

  task automatic note_mismatch(string what, rgb_res_t want, rgb_res_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t: %s: expected r=%0d g=%0d b=%0d grb=%06h, got r=%0d g=%0d b=%0d grb=%06h",
               $realtime, what, want.red, want.green, want.blue, want.grb,
               got.red, got.green, got.blue, got.grb);
    end
  endtask

  // Request driver. A new request is presented only after the previous one has
  // been taken, so a stalled request stays stable. Between requests the driver
  // can insert an idle burst.
  logic req_taken = 1'b0;
  int unsigned send_gap = 0;
  hsv_req_t drv_req;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_gap  = 0;
      req_taken = 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!calm_mode && $urandom_range(0, 99) < idle_pct) begin
        send_gap = $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (color_req_q.size() != 0) begin
        drv_req = color_req_q.pop_front();
        in_hue_deg    <= drv_req.hue;
        in_saturation <= drv_req.sat;
        in_brightness <= drv_req.bri;
        in_valid      <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The prediction is taken at the edge where the request is accepted. The gains
  // cannot change while requests are in flight, so this matches the block.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      rgb_expected_q.push_back(hsv_predict('{in_hue_deg, in_saturation, in_brightness}));
      req_taken = 1'b1;
    end
  end

  // Result stall. It follows the same burst pattern as the driver and is applied
  // on the falling edge.
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (!rst_n || calm_mode) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor.
  rgb_res_t mon_want;
  rgb_res_t mon_got;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      mon_got = '{out_red_out, out_green_out, out_blue_out, out_packed_grb};
      if (rgb_expected_q.size() == 0) begin
        note_mismatch("unexpected result", '0, mon_got);
      end else begin
        mon_want = rgb_expected_q.pop_front();
        if (mon_got.red !== mon_want.red || mon_got.green !== mon_want.green ||
            mon_got.blue !== mon_want.blue || mon_got.grb !== mon_want.grb) begin
          note_mismatch("color mismatch", mon_want, mon_got);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    hsv_req_t req;
    chan_gain[hsvrgb_pkg::RegRedGain]   = hsvrgb_pkg::RedGainRst;
    chan_gain[hsvrgb_pkg::RegGreenGain] = hsvrgb_pkg::GreenGainRst;
    chan_gain[hsvrgb_pkg::RegBlueGain]  = hsvrgb_pkg::BlueGainRst;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset gains. It covers the edges of every band,
    // out-of-range hues, zero and full saturation and brightness, and grey.
    idle_pct = 30;
    for (int i = 0; i < 17; i++) begin
      req.hue = (i < 12) ? hsvrgb_pkg::HueW'((i / 2) * 60 + ((i % 2) ? 59 : 0))
                         : hsvrgb_pkg::HueW'(360 + (i - 12) * 37);
      req.sat = hsvrgb_pkg::FracOne;
      req.bri = hsvrgb_pkg::FracOne;
      color_req_q.push_back(req);
    end
    color_req_q.push_back('{hsvrgb_pkg::Hue480, hsvrgb_pkg::FracOne, hsvrgb_pkg::FracOne});
    color_req_q.push_back('{9'd511, hsvrgb_pkg::FracOne, hsvrgb_pkg::FracOne});
    color_req_q.push_back('{9'd200, 8'd0, hsvrgb_pkg::FracOne});
    color_req_q.push_back('{9'd30, hsvrgb_pkg::FracOne, 8'd0});
    color_req_q.push_back('{9'd0, 8'd0, 8'd0});
    color_req_q.push_back('{9'd30, 8'd128, 8'd200});
    color_req_q.push_back('{9'd90, 8'd1, 8'd1});
    color_req_q.push_back('{9'd330, 8'd254, 8'd254});
    wait_idle();

    // Full-scale gains, plus a write to the unused index that must be ignored.
    set_gains(8'd255, 8'd255, 8'd255);
    set_gain(RegUnused, 8'd0);
    run_random(350, 30);

    // Zero gains force every channel to zero.
    set_gains(8'd0, 8'd0, 8'd0);
    run_random(150, 50);

    // Small, middle and near-full gains, run back to back without idling.
    set_gains(8'd1, 8'd128, 8'd254);
    run_random(350, 0);

    set_gains(hsvrgb_pkg::chan_t'($urandom_range(0, 255)),
              hsvrgb_pkg::chan_t'($urandom_range(0, 255)),
              hsvrgb_pkg::chan_t'($urandom_range(0, 255)));
    run_random(350, 40);

    set_gains(hsvrgb_pkg::RedGainRst, hsvrgb_pkg::GreenGainRst, hsvrgb_pkg::BlueGainRst);
    run_random(350, 25);

    // The final stretch runs with no idling on either side.
    calm_mode = 1'b1;
    set_gains(hsvrgb_pkg::chan_t'($urandom_range(0, 255)),
              hsvrgb_pkg::chan_t'($urandom_range(0, 255)),
              hsvrgb_pkg::chan_t'($urandom_range(0, 255)));
    run_random(250, 0);

    if (mismatch_count == 0 && rgb_expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog. The slowest correct run, with both sides stalling in bursts the
  // whole time, needs well under a tenth of this.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/hsvrgb_pkg.sv
hdl/hsv_to_rgb_channel_scaled.sv
verif/tb_hsv_to_rgb_channel_scaled.sv
